[hdl/fpcm_pkg.sv]
// Shared types and constants for the float/PCM sample converter.
// No dependencies; imported by fpcm_round and float_pcm_sample_converter_unit.
package fpcm_pkg;

  typedef enum logic [1:0] {
    OP_F2S16 = 2'd0,
    OP_F2S32 = 2'd1,
    OP_S16F  = 2'd2
  } op_t;

  localparam int  PROD_W   = 55;
  localparam int  RND_W    = 56;
  localparam logic [31:0] FLT_ONE = 32'h3F80_0000;
  localparam logic [7:0]  EXP_ONE = 8'd127;
  localparam logic [7:0]  SH_BASE = 8'd150;
  localparam logic [7:0]  S16_EXP_BASE = 8'd111;

  typedef struct packed {
    logic              wide;
    logic [PROD_W-1:0] prod;
  } rnd_in_t;

endpackage

[hdl/fpcm_round.sv]
// Rounds a scaled mantissa product to 24 or 53 significant bits, ties to even.
// Depends on fpcm_pkg.
module fpcm_round (
  input  fpcm_pkg::rnd_in_t             rin,
  output logic [fpcm_pkg::RND_W-1:0]    rounded
);
  import fpcm_pkg::*;

  logic [3:0]       shr;
  logic [5:0]       rpos;
  logic [RND_W-1:0] p;
  logic [RND_W-1:0] q;
  logic [RND_W-1:0] mask;
  logic             rbit;
  logic             sticky;
  logic             up;

  always_comb begin
    if (rin.wide) begin
      shr = rin.prod[54] ? 4'd2 : 4'd1;
    end else begin
      shr = rin.prod[38] ? 4'd15 : 4'd14;
    end
    rpos   = {2'b00, shr} - 6'd1;
    p      = {1'b0, rin.prod};
    q      = p >> shr;
    mask   = (RND_W'(1) << (shr - 4'd1)) - RND_W'(1);
    rbit   = p[rpos];
    sticky = |(p & mask);
    up     = rbit & (sticky | q[0]);
    rounded = (q + RND_W'(up)) << shr;
  end

endmodule

[hdl/float_pcm_sample_converter_unit.sv]
// Float/PCM sample converter top level: four-stage stream pipeline.
// Depends on fpcm_pkg and fpcm_round.
//
// One sample per item, one result per item, at one item per clock unless the
// output stalls; m_tdata is the last stage's register. Stages: clamp and
// decode (and the whole 16-bit to float path), scale by shift-and-subtract,
// round to 24 or 53 bits, then align, negate and select. Each stage holds its
// own valid bit and advances on its own, so bubbles fill while the output is
// stalled. s_tuser selects the conversion; code 3 yields zero.
module float_pcm_sample_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_in
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] sample_out
);
  import fpcm_pkg::*;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1, v2, v3, v4;

  logic [7:0]  e_in;
  logic [22:0] f_in;
  logic        nan_in, big_in;
  logic [7:0]  ee_c;
  logic [22:0] f_c;
  logic [15:0] v16;
  logic [31:0] m16;
  logic [3:0]  b16;
  logic [31:0] frac16;
  logic [31:0] alt_next;

  logic [1:0]  op1, op2, op3;
  logic        neg1, neg2, neg3;
  logic        zero1, zero2, zero3;
  logic [23:0] mant1;
  logic [7:0]  sh1, sh2, sh3;
  logic [31:0] alt1, alt2, alt3;
  logic [PROD_W-1:0] prod2;
  logic [PROD_W-1:0] prod_next;
  logic [RND_W-1:0]  pr3;
  logic [RND_W-1:0]  pr_next;
  logic [RND_W-1:0]  shifted;
  logic [31:0] mag;
  logic [31:0] res_next;
  logic [31:0] res4;
  rnd_in_t     rin;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v4;
  assign m_tdata  = res4;

  always_comb begin
    e_in   = s_tdata[30:23];
    f_in   = s_tdata[22:0];
    nan_in = (e_in == 8'hFF) && (f_in != 23'd0);
    big_in = (e_in > EXP_ONE) || ((e_in == EXP_ONE) && (f_in != 23'd0));
    ee_c   = big_in ? EXP_ONE : e_in;
    f_c    = big_in ? 23'd0 : f_in;

    v16 = s_tdata[15:0];
    m16 = v16[15] ? {16'd0, 16'd0 - v16} : {16'd0, v16};
    b16 = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (m16[i]) b16 = 4'(i + 1);
    end
    frac16 = (m16 << (5'd24 - {1'b0, b16})) & 32'h007F_FFFF;
    if (v16 == 16'h8000) begin
      alt_next = FLT_ONE | 32'h8000_0000;
    end else if (v16 == 16'h7FFF) begin
      alt_next = FLT_ONE;
    end else if (v16 == 16'd0) begin
      alt_next = 32'd0;
    end else begin
      alt_next = {v16[15], S16_EXP_BASE + {4'd0, b16}, frac16[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
    if (rdy1) begin
      op1   <= s_tuser;
      neg1  <= s_tdata[31];
      zero1 <= nan_in || (ee_c == 8'd0);
      mant1 <= {1'b1, f_c};
      sh1   <= SH_BASE - ee_c;
      alt1  <= alt_next;
    end
  end

  assign prod_next = (op1 == OP_F2S32)
                   ? ({31'd0, mant1} << 31) - {31'd0, mant1}
                   : ({31'd0, mant1} << 15) - {31'd0, mant1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      op2   <= op1;
      neg2  <= neg1;
      zero2 <= zero1;
      sh2   <= sh1;
      alt2  <= alt1;
      prod2 <= prod_next;
    end
  end

  assign rin.wide = (op2 == OP_F2S32);
  assign rin.prod = prod2;

  fpcm_round u_round (
    .rin     (rin),
    .rounded (pr_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      op3   <= op2;
      neg3  <= neg2;
      zero3 <= zero2;
      sh3   <= sh2;
      alt3  <= alt2;
      pr3   <= pr_next;
    end
  end

  always_comb begin
    shifted = pr3 >> sh3;
    if (zero3 || (sh3 >= 8'(RND_W))) begin
      mag = 32'd0;
    end else begin
      mag = shifted[31:0];
    end
    case (op3)
      OP_F2S16, OP_F2S32: res_next = neg3 ? 32'd0 - mag : mag;
      OP_S16F:            res_next = alt3;
      default:            res_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      res4 <= res_next;
    end
  end

  a_undef_op_zero: assert property (@(posedge clk) disable iff (rst)
    (rdy4 && v3 && op3 != OP_F2S16 && op3 != OP_F2S32 && op3 != OP_S16F)
      |=> (m_tdata == 32'd0))
    else $error("undefined operation gave nonzero result");

  a_s16_range: assert property (@(posedge clk) disable iff (rst)
    (rdy4 && v3 && op3 == OP_F2S16)
      |=> ((m_tdata[31:15] == 17'd0 || m_tdata[31:15] == 17'h1FFFF)
           && m_tdata != 32'hFFFF_8000))
    else $error("16-bit result out of range");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (rdy4 && v3 && zero3 && (op3 == OP_F2S16 || op3 == OP_F2S32))
      |=> (m_tdata == 32'd0))
    else $error("NaN or tiny input gave nonzero result");

endmodule
